>>> sv/tctrim_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tctrim_pkg;

  localparam int NumChannelsDef = 8;
  localparam int CoefsPerChannel = 4;
  localparam int TempW = 7;
  localparam int CoefW = 32;
  localparam int SumW = 40;
  localparam int NumW = 51;
  localparam int DenW = 50;
  localparam int Cells = 17;
  localparam int CurW = 16;

  localparam logic [TempW-1:0] TempNegCap = 7'd45;
  localparam logic [TempW-1:0] TempPosCap = 7'd105;
  localparam logic [SumW-1:0] ZeroGainDiv = 40'd32768;
  localparam int CurShift = 25;

  localparam logic [1:0] SelGainSlope = 2'd0;
  localparam logic [1:0] SelGainBase = 2'd1;
  localparam logic [1:0] SelOffSlope = 2'd2;
  localparam logic [1:0] SelOffBase = 2'd3;

  typedef struct packed {
    logic [NumW-1:0]  rem;
    logic [DenW-1:0]  den;
    logic [Cells-1:0] quo;
    logic             zero;
  } div_t;

endpackage
`default_nettype wire

>>> sv/temp_compensated_current_trim.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel  Handshake            Fields
// in       in_valid_i/ready_o   operation, channel, coef_select, coef_value,
//                               board_temp, raw_current
// out      out_valid_o/ready_i  trimmed_current
//
// One item per cycle sustained while out_ready_i keeps up; each accepted
// correct item passes through table read, multiply, add, scale, sign split,
// then one divider cell per quotient bit (17 cells) and the output register.
// A write item updates the table at its accept edge and yields no result.
// Each stage holds under backpressure and fills bubbles left by write items.
// Reset clears only valid flags; the table is undefined until written.
module temp_compensated_current_trim #(
  parameter int NumChannels = tctrim_pkg::NumChannelsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        operation_i,
  input  wire logic [3:0]  channel_i,
  input  wire logic [1:0]  coef_select_i,
  input  wire logic signed [31:0] coef_value_i,
  input  wire logic signed [8:0]  board_temp_i,
  input  wire logic [15:0] raw_current_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [15:0]      trimmed_current_o
);
  import tctrim_pkg::*;

  localparam int Aw = (NumChannels > 1) ? $clog2(NumChannels) : 1;

  logic ch_ok, wr_en, a_rdy, b_rdy, c_rdy, d_rdy, e_rdy, o_rdy;
  logic [CoefW-1:0] rd [CoefsPerChannel];
  logic [8:0] t_mag;
  logic [TempW-1:0] t_cond;

  logic a_v_q, a_ok_q;
  logic [TempW-1:0] a_t_q;
  logic [CurW-1:0] a_cur_q;

  logic b_v_q, b_ok_q;
  logic signed [SumW-1:0] b_pg_q, b_po_q;
  logic [CoefW-1:0] b_c1_q, b_c3_q;
  logic [CurW-1:0] b_cur_q;

  logic c_v_q, c_ok_q;
  logic signed [SumW-1:0] c_gain_q, c_off_q;
  logic [CurW-1:0] c_cur_q;

  logic d_v_q, d_ok_q;
  logic signed [NumW-1:0] d_num_q;
  logic signed [DenW-1:0] d_den_q;
  logic [SumW-1:0] gsel;

  logic e_v_q;
  div_t e_q;

  div_t cdat [Cells+1];
  logic cv [Cells+1];
  logic cr [Cells+1];

  logic o_v_q;
  logic [CurW-1:0] o_q;

  assign ch_ok = {1'b0, channel_i} < 5'(NumChannels);
  assign wr_en = in_valid_i && in_ready_o && !operation_i && ch_ok;

  for (genvar k = 0; k < CoefsPerChannel; k++) begin : g_ram
    tctrim_ram #(.Width(CoefW), .Depth(NumChannels)) u_ram (
      .clk_i   (clk_i),
      .we_i    (wr_en && (coef_select_i == 2'(k))),
      .waddr_i (channel_i[Aw-1:0]),
      .wdata_i (coef_value_i),
      .re_i    (a_rdy),
      .raddr_i (channel_i[Aw-1:0]),
      .rdata_o (rd[k])
    );
  end

  always_comb begin
    t_mag = board_temp_i[8] ? (9'd0 - board_temp_i) : board_temp_i;
    if (board_temp_i[8]) begin
      t_cond = (t_mag > {2'b00, TempNegCap}) ? TempNegCap : t_mag[TempW-1:0];
    end else begin
      t_cond = (t_mag > {2'b00, TempPosCap}) ? TempPosCap : t_mag[TempW-1:0];
    end
  end

  assign o_rdy = !o_v_q || out_ready_i;
  assign cr[Cells] = o_rdy;
  assign e_rdy = !e_v_q || cr[0];
  assign d_rdy = !d_v_q || e_rdy;
  assign c_rdy = !c_v_q || d_rdy;
  assign b_rdy = !b_v_q || c_rdy;
  assign a_rdy = !a_v_q || b_rdy;
  assign in_ready_o = a_rdy;

  assign cv[0] = e_v_q;
  assign cdat[0] = e_q;
  for (genvar i = 0; i < Cells; i++) begin : g_cell
    tctrim_cell #(.Shift(Cells - 1 - i)) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (cv[i]),
      .in_data_i   (cdat[i]),
      .in_ready_o  (cr[i]),
      .out_valid_o (cv[i+1]),
      .out_data_o  (cdat[i+1]),
      .out_ready_i (cr[i+1])
    );
  end

  assign gsel = (c_gain_q == '0) ? ZeroGainDiv : c_gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
      d_v_q <= 1'b0;
      e_v_q <= 1'b0;
      o_v_q <= 1'b0;
    end else begin
      if (a_rdy) a_v_q <= in_valid_i && operation_i;
      if (b_rdy) b_v_q <= a_v_q;
      if (c_rdy) c_v_q <= b_v_q;
      if (d_rdy) d_v_q <= c_v_q;
      if (e_rdy) e_v_q <= d_v_q;
      if (o_rdy) o_v_q <= cv[Cells];
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_rdy) begin
      a_ok_q  <= ch_ok;
      a_t_q   <= t_cond;
      a_cur_q <= raw_current_i;
    end
    if (b_rdy) begin
      b_ok_q  <= a_ok_q;
      b_cur_q <= a_cur_q;
      b_c1_q  <= rd[SelGainBase];
      b_c3_q  <= rd[SelOffBase];
      b_pg_q  <= $signed({33'd0, a_t_q}) * $signed({{8{rd[SelGainSlope][31]}},
                 rd[SelGainSlope]});
      b_po_q  <= $signed({33'd0, a_t_q}) * $signed({{8{rd[SelOffSlope][31]}},
                 rd[SelOffSlope]});
    end
    if (c_rdy) begin
      c_ok_q   <= b_ok_q;
      c_cur_q  <= b_cur_q;
      c_gain_q <= b_pg_q + $signed({{8{b_c1_q[31]}}, b_c1_q});
      c_off_q  <= b_po_q + $signed({{8{b_c3_q[31]}}, b_c3_q});
    end
    if (d_rdy) begin
      d_ok_q  <= c_ok_q;
      d_num_q <= $signed(NumW'(c_cur_q) << CurShift)
               - $signed({{(NumW-SumW){c_off_q[SumW-1]}}, c_off_q}) * 51'sd1000;
      d_den_q <= $signed({{(DenW-SumW){gsel[SumW-1]}}, gsel}) * 50'sd1000;
    end
    if (e_rdy) begin
      e_q.rem  <= d_num_q[NumW-1] ? NumW'(-d_num_q) : NumW'(d_num_q);
      e_q.den  <= d_den_q[DenW-1] ? DenW'(-d_den_q) : DenW'(d_den_q);
      e_q.quo  <= '0;
      e_q.zero <= !d_ok_q || (d_num_q[NumW-1] ^ d_den_q[DenW-1]);
    end
    if (o_rdy) begin
      if (cdat[Cells].zero) begin
        o_q <= '0;
      end else if (cdat[Cells].quo[Cells-1]) begin
        o_q <= '1;
      end else begin
        o_q <= cdat[Cells].quo[CurW-1:0];
      end
    end
  end

  assign out_valid_o = o_v_q;
  assign trimmed_current_o = o_q;

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> a_v_q) else $error("input stalled with empty first stage");
  a_bad_channel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && operation_i && !ch_ok) |=> (a_v_q && !a_ok_q))
    else $error("out of range channel not flagged");
  a_write_bubble: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && !operation_i) |=> !a_v_q)
    else $error("write item entered the datapath");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (e_v_q && !cr[0]) |=> (e_v_q && $stable(e_q.rem)))
    else $error("divider input lost under stall");

endmodule
`default_nettype wire

>>> sv/tctrim_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module tctrim_ram #(
  parameter int Width = 32,
  parameter int Depth = 8,
  localparam int Aw = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [Aw-1:0]    waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [Aw-1:0]    raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

>>> sv/tctrim_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module tctrim_cell #(
  parameter int Shift = 0
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire tctrim_pkg::div_t  in_data_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  output tctrim_pkg::div_t       out_data_o,
  input  wire logic              out_ready_i
);
  import tctrim_pkg::*;

  logic            v_q;
  div_t            data_q, data_d;
  logic [NumW-1:0] hi, lowmask;
  logic [NumW:0]   diff;
  logic            ge;

  assign in_ready_o  = !v_q || out_ready_i;
  assign out_valid_o = v_q;
  assign out_data_o  = data_q;

  always_comb begin
    hi      = in_data_i.rem >> Shift;
    lowmask = (NumW'(1) << Shift) - NumW'(1);
    diff    = {1'b0, hi} - {2'b00, in_data_i.den};
    ge      = !diff[NumW];
    data_d  = in_data_i;
    data_d.quo = {in_data_i.quo[Cells-2:0], ge};
    if (ge) begin
      data_d.rem = (diff[NumW-1:0] << Shift) | (in_data_i.rem & lowmask);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (in_ready_o) begin
      v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o) begin
      data_q <= data_d;
    end
  end

endmodule
`default_nettype wire

>>> tb/sv/trim_checker.sv
`timescale 1ns / 1ps
module trim_checker #(
  parameter int NumChannels = tctrim_pkg::NumChannelsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic                operation_i,
  input  logic [3:0]          channel_i,
  input  logic [1:0]          coef_select_i,
  input  logic signed [31:0]  coef_value_i,
  input  logic signed [8:0]   board_temp_i,
  input  logic [15:0]         raw_current_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic [15:0]         trimmed_current_i,
  output int                  fail_count_o,
  output int                  pending_o,
  output int                  accepted_o,
  output int                  corrects_o,
  output int                  writes_o
);
  import tctrim_pkg::*;

  logic signed [31:0] coef_mem [NumChannels*CoefsPerChannel];
  logic [15:0]        trimmed_q [$];

  function automatic logic [15:0] trim_current(input logic [3:0] ch,
                                               input logic signed [8:0] tin,
                                               input logic [15:0] cur);
    longint t;
    longint gain;
    longint offs;
    longint num;
    longint den;
    longint q;
    if (ch >= NumChannels) return 16'd0;
    t = tin;
    if (t < 0) begin
      t = -t;
      if (t > 45) t = 45;
    end else if (t > 105) begin
      t = 105;
    end
    gain = t * longint'(coef_mem[ch*4 + SelGainSlope]) + longint'(coef_mem[ch*4 + SelGainBase]);
    offs = t * longint'(coef_mem[ch*4 + SelOffSlope]) + longint'(coef_mem[ch*4 + SelOffBase]);
    num = longint'(cur) * 64'sd33554432 - 64'sd1000 * offs;
    den = 64'sd1000 * ((gain == 0) ? 64'sd32768 : gain);
    q = num / den;
    if (q < 0) q = 0;
    if (q > 65535) q = 65535;
    return q[15:0];
  endfunction

  assign pending_o = trimmed_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    logic [15:0] want;
    if (!rst_ni) begin
      fail_count_o <= 0;
      accepted_o <= 0;
      corrects_o <= 0;
      writes_o <= 0;
      trimmed_q.delete();
      for (int i = 0; i < NumChannels*CoefsPerChannel; i++) coef_mem[i] = '0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (trimmed_q.size() == 0) begin
          $display("%0t: unexpected item, expected none, actual %0d", $time,
                   trimmed_current_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = trimmed_q.pop_front();
          if (want !== trimmed_current_i) begin
            $display("%0t: trimmed_current expected %0d actual %0d", $time, want,
                     trimmed_current_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        accepted_o <= accepted_o + 1;
        if (operation_i) begin
          trimmed_q.push_back(trim_current(channel_i, board_temp_i, raw_current_i));
          corrects_o <= corrects_o + 1;
        end else begin
          writes_o <= writes_o + 1;
          if (channel_i < NumChannels) coef_mem[channel_i*4 + coef_select_i] = coef_value_i;
        end
      end
    end
  end
endmodule

>>> tb/sv/tb_temp_compensated_current_trim.sv
`timescale 1ns / 1ps
module tb_temp_compensated_current_trim;
  import tctrim_pkg::*;

  localparam int NumCh = NumChannelsDef;
  localparam int OpWrite = 0;
  localparam int OpCorrect = 1;
  localparam int IdleLimit = 4000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic               operation_i = 1'b0;
  logic [3:0]         channel_i = '0;
  logic [1:0]         coef_select_i = '0;
  logic signed [31:0] coef_value_i = '0;
  logic signed [8:0]  board_temp_i = '0;
  logic [15:0]        raw_current_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [15:0]        trimmed_current_o;
  int fail_count, pending, accepted, corrects, writes;
  int idle_cycles = 0;
  bit stall_en = 1'b1;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  temp_compensated_current_trim #(.NumChannels(NumCh)) u_top (.*);

  trim_checker #(.NumChannels(NumCh)) u_check (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .operation_i, .channel_i,
    .coef_select_i, .coef_value_i, .board_temp_i, .raw_current_i,
    .out_valid_i(out_valid_o), .out_ready_i, .trimmed_current_i(trimmed_current_o),
    .fail_count_o(fail_count), .pending_o(pending), .accepted_o(accepted),
    .corrects_o(corrects), .writes_o(writes)
  );

  always @(negedge clk_i) begin
    int phase;
    phase = $urandom_range(0, 15);
    if (!stall_en) out_ready_i <= 1'b1;
    else out_ready_i <= (phase < 3) ? 1'b0 : (phase < 5 ? $urandom_range(0, 1) : 1'b1);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IdleLimit) begin
      $display("watchdog: no progress for %0d cycles", IdleLimit);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_item(input bit op, input logic [3:0] ch, input logic [1:0] sel,
                           input logic signed [31:0] val, input logic signed [8:0] temp,
                           input logic [15:0] cur);
    operation_i <= op;
    channel_i <= ch;
    coef_select_i <= sel;
    coef_value_i <= val;
    board_temp_i <= temp;
    raw_current_i <= cur;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic end_burst();
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
    if (gap == 0) return;
    in_valid_i <= 1'b0;
    repeat (gap) @(negedge clk_i);
  endtask

  function automatic logic signed [31:0] rand_coef();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $urandom;
      3: return $signed($urandom_range(0, 2000)) - 1000;
      default: return $signed($urandom_range(0, 200000)) - 20000;
    endcase
  endfunction

  task automatic load_channel(input logic [3:0] ch, input bit mild);
    for (int s = 0; s < CoefsPerChannel; s++) begin
      logic signed [31:0] v;
      if (mild) begin
        case (s)
          SelGainSlope: v = $signed($urandom_range(0, 40)) - 20;
          SelGainBase:  v = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 2000);
          SelOffSlope:  v = $signed($urandom_range(0, 2000)) - 1000;
          default:      v = $signed($urandom_range(0, 200000)) - 100000;
        endcase
      end else begin
        v = rand_coef();
      end
      send_item(OpWrite, ch, s[1:0], v, $urandom, $urandom);
    end
  endtask

  initial begin
    logic signed [8:0] temps [8] = '{-9'sd256, -9'sd46, -9'sd45, -9'sd1, 9'sd0, 9'sd105,
                                     9'sd106, 9'sd255};
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int c = 0; c < NumCh; c++) load_channel(c[3:0], c != 0);
    send_item(OpWrite, 4'd15, SelGainBase, 32'sh7fffffff, 9'sd0, 16'd0);
    send_item(OpWrite, 4'd0, SelGainSlope, 32'sd0, 9'sd0, 16'd0);
    send_item(OpWrite, 4'd0, SelGainBase, 32'sd0, 9'sd0, 16'd0);
    for (int k = 0; k < 8; k++)
      send_item(OpCorrect, k[3:0], $urandom, $urandom, temps[k], k[0] ? 16'hffff : 16'd0);
    send_item(OpCorrect, 4'd15, 2'd0, 32'sd0, 9'sd20, 16'hffff);
    send_item(OpCorrect, NumCh, 2'd0, 32'sd0, 9'sd20, 16'h1234);
    end_burst();

    for (int n = 0; n < 1200; n++) begin
      int r;
      r = $urandom_range(0, 19);
      if (n == 700) stall_en = 1'b0;
      if (n == 1000) stall_en = 1'b1;
      if (r == 0) load_channel($urandom_range(0, NumCh - 1), $urandom_range(0, 3) != 0);
      else if (r == 1) send_item(OpWrite, $urandom, $urandom, rand_coef(), $urandom, $urandom);
      else send_item(OpCorrect, $urandom_range(0, 7) == 0 ? $urandom : $urandom_range(0, NumCh-1),
                     $urandom, $urandom, $urandom, $urandom);
      if ($urandom_range(0, 7) == 0) end_burst();
    end
    in_valid_i <= 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
    $display("covered %0d items: %0d corrections, %0d coefficient writes", accepted,
             corrects, writes);
    $display("temperature caps, zero gain, out-of-range channels and saturation exercised");
    if (fail_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule

>>> temp_compensated_current_trim.f
sv/tctrim_pkg.sv
sv/tctrim_ram.sv
sv/tctrim_cell.sv
sv/temp_compensated_current_trim.sv
tb/sv/trim_checker.sv
tb/sv/tb_temp_compensated_current_trim.sv
